>>> rtl/scrgb_pkg.sv
package scrgb_pkg;

    // Widths of the datapath ahead of the divider.
    localparam int SAMPLE_W = 32;
    localparam int DIFF_W   = SAMPLE_W + 1;
    localparam int NUM_W    = SAMPLE_W + 1;
    localparam int SEG_W    = 2;

    localparam logic [SEG_W-1:0] SEG_FIRST = 2'd0;
    localparam logic [SEG_W-1:0] SEG_LAST  = 2'd3;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_rgb;

    // Control that travels alongside each item through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             below;
        logic             above;
        logic [SEG_W-1:0] seg;
    } t_ctl;

    function automatic t_rgb ramp_color(input logic [2:0] idx);
        t_rgb c;
        unique case (idx)
            3'd0:    c = '{red: 8'd0,   green: 8'd0,   blue: 8'd255};
            3'd1:    c = '{red: 8'd0,   green: 8'd204, blue: 8'd255};
            3'd2:    c = '{red: 8'd0,   green: 8'd153, blue: 8'd0};
            3'd3:    c = '{red: 8'd255, green: 8'd204, blue: 8'd0};
            default: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

endpackage

>>> rtl/scalar_to_rgb_color_map.sv
// Channel  Direction  Ports                                        Handshake
// sample   in         i_sample_value                               i_start, o_busy
// colour   out        o_red, o_green, o_blue, o_segment,           o_valid strobe
//                     o_out_of_range
// config   in         i_cfg_idx, i_cfg_wdata                       i_cfg_wr_en
//
// One item is taken every cycle; o_busy stays low.
// Each result passes through three stages of offset, range check and segment
// choice, one restoring divider stage per fraction bit, one blend stage and
// the output register.
// Reset is synchronous, clears the valid bits and loads the range registers
// with their reset values.
// Results are shown for a single cycle and cannot be held off.
module scalar_to_rgb_color_map
    import scrgb_pkg::*;
#(
    parameter int FRACTION_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  logic signed [SAMPLE_W-1:0] i_sample_value,
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_idx,
    input  logic [SAMPLE_W-1:0]        i_cfg_wdata,
    output logic                       o_valid,
    output logic [7:0]                 o_red,
    output logic [7:0]                 o_green,
    output logic [7:0]                 o_blue,
    output logic [SEG_W-1:0]           o_segment,
    output logic                       o_out_of_range
);

    localparam int  LATENCY       = FRACTION_BITS + 5;
    localparam logic CFG_RANGE_MIN = 1'b0;
    localparam logic CFG_RANGE_MAX = 1'b1;

    logic signed [SAMPLE_W-1:0] r_range_min;
    logic signed [SAMPLE_W-1:0] r_range_max;

    t_ctl                     ctl [0:FRACTION_BITS];
    logic [NUM_W-1:0]         rem [0:FRACTION_BITS];
    logic [NUM_W-1:0]         den [0:FRACTION_BITS];
    logic [FRACTION_BITS-1:0] quo [0:FRACTION_BITS];

    assign o_busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_range_min <= 32'sd4280;
            r_range_max <= 32'sd6456689;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_idx)
                CFG_RANGE_MIN: r_range_min <= i_cfg_wdata;
                CFG_RANGE_MAX: r_range_max <= i_cfg_wdata;
            endcase
        end
    end

    scrgb_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_start),
        .i_sample    (i_sample_value),
        .i_range_min (r_range_min),
        .i_range_max (r_range_max),
        .o_ctl       (ctl[0]),
        .o_num       (rem[0]),
        .o_den       (den[0])
    );

    assign quo[0] = '0;

    for (genvar i = 0; i < FRACTION_BITS; i++) begin : g_div
        scrgb_div_step #(.FB(FRACTION_BITS)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[i]),
            .i_rem   (rem[i]),
            .i_den   (den[i]),
            .i_quo   (quo[i]),
            .o_ctl   (ctl[i+1]),
            .o_rem   (rem[i+1]),
            .o_den   (den[i+1]),
            .o_quo   (quo[i+1])
        );
    end

    scrgb_blend #(.FB(FRACTION_BITS)) u_blend (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (ctl[FRACTION_BITS]),
        .i_frac         (quo[FRACTION_BITS]),
        .o_valid        (o_valid),
        .o_red          (o_red),
        .o_green        (o_green),
        .o_blue         (o_blue),
        .o_segment      (o_segment),
        .o_out_of_range (o_out_of_range)
    );

    a_start_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##LATENCY o_valid)
        else $error("item accepted without a result after the pipeline latency");

    a_idle_gives_nothing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_start |-> ##LATENCY !o_valid)
        else $error("result produced without an accepted item");

    a_clamp_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range |-> (o_segment == SEG_FIRST || o_segment == SEG_LAST))
        else $error("clamped item on an inner segment");

    a_clamp_low_colour: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out_of_range && o_segment == SEG_FIRST
            |-> o_red == 8'd0 && o_green == 8'd0 && o_blue == 8'd255)
        else $error("low clamp does not give the first ramp colour");

endmodule

>>> rtl/scrgb_front.sv
module scrgb_front
    import scrgb_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    input  logic signed [SAMPLE_W-1:0] i_sample,
    input  logic signed [SAMPLE_W-1:0] i_range_min,
    input  logic signed [SAMPLE_W-1:0] i_range_max,
    output t_ctl                       o_ctl,
    output logic [NUM_W-1:0]           o_num,
    output logic [NUM_W-1:0]           o_den
);

    // Stage 1: offset from the range start and range width.
    logic              r_valid1;
    logic [DIFF_W-1:0] r_d1;
    logic [DIFF_W-1:0] r_w1;

    // Stage 2: range checks, 5*d and 3*w.
    logic              r_valid2;
    logic              r_below2;
    logic              r_above2;
    logic [34:0]       r_d_x5;
    logic [31:0]       r_w2;
    logic [33:0]       r_w_x3;

    // Stage 3: segment choice and the divider operands.
    t_ctl              r_ctl3;
    logic [NUM_W-1:0]  r_num3;
    logic [NUM_W-1:0]  r_den3;

    logic [DIFF_W-1:0] n_d1;
    logic [DIFF_W-1:0] n_w1;
    logic [35:0]       diff1;
    logic [35:0]       diff2;
    logic [35:0]       diff3;
    t_ctl              n_ctl3;
    logic [NUM_W-1:0]  n_num3;
    logic [NUM_W-1:0]  n_den3;

    assign n_d1 = {i_sample[SAMPLE_W-1], i_sample} - {i_range_min[SAMPLE_W-1], i_range_min};
    assign n_w1 = {i_range_max[SAMPLE_W-1], i_range_max}
                - {i_range_min[SAMPLE_W-1], i_range_min};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid1 <= 1'b0;
            r_valid2 <= 1'b0;
        end else begin
            r_valid1 <= i_valid;
            r_valid2 <= r_valid1;
        end
        r_d1 <= n_d1;
        r_w1 <= n_w1;
        r_below2 <= r_d1[DIFF_W-1];
        r_above2 <= !r_d1[DIFF_W-1] && ($signed(r_d1) >= $signed(r_w1));
        // Within range both d and w are below 2^32, so their low words suffice.
        r_d_x5 <= {1'b0, r_d1[31:0], 2'b00} + {3'b000, r_d1[31:0]};
        r_w2   <= r_w1[31:0];
        r_w_x3 <= {1'b0, r_w1[31:0], 1'b0} + {2'b00, r_w1[31:0]};
    end

    assign diff1 = {1'b0, r_d_x5} - {4'b0000, r_w2};
    assign diff2 = {1'b0, r_d_x5} - {3'b000, r_w2, 1'b0};
    assign diff3 = {1'b0, r_d_x5} - {2'b00, r_w_x3};

    always_comb begin
        n_ctl3.valid = r_valid2;
        n_ctl3.below = r_below2;
        n_ctl3.above = r_above2;
        n_den3       = {1'b0, r_w2};
        priority if (diff1[35]) begin
            n_ctl3.seg = 2'd0;
            n_num3     = r_d_x5[NUM_W-1:0];
        end else if (diff2[35]) begin
            n_ctl3.seg = 2'd1;
            n_num3     = diff1[NUM_W-1:0];
        end else if (diff3[35]) begin
            n_ctl3.seg = 2'd2;
            n_num3     = diff2[NUM_W-1:0];
        end else begin
            // The last segment spans two increments.
            n_ctl3.seg = SEG_LAST;
            n_num3     = diff3[NUM_W-1:0];
            n_den3     = {r_w2, 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3 <= '0;
        end else begin
            r_ctl3 <= n_ctl3;
        end
        r_num3 <= n_num3;
        r_den3 <= n_den3;
    end

    assign o_ctl = r_ctl3;
    assign o_num = r_num3;
    assign o_den = r_den3;

endmodule

>>> rtl/scrgb_div_step.sv
module scrgb_div_step
    import scrgb_pkg::*;
#(
    parameter int FB = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [NUM_W-1:0] i_rem,
    input  logic [NUM_W-1:0] i_den,
    input  logic [FB-1:0]    i_quo,
    output t_ctl             o_ctl,
    output logic [NUM_W-1:0] o_rem,
    output logic [NUM_W-1:0] o_den,
    output logic [FB-1:0]    o_quo
);

    t_ctl             r_ctl;
    logic [NUM_W-1:0] r_rem;
    logic [NUM_W-1:0] r_den;
    logic [FB-1:0]    r_quo;

    logic [NUM_W:0]   shifted;
    logic [NUM_W+1:0] diff;
    logic             q_bit;
    logic [NUM_W-1:0] n_rem;

    // One restoring step: the remainder stays below the divisor throughout.
    assign shifted = {i_rem, 1'b0};
    assign diff    = {1'b0, shifted} - {2'b00, i_den};
    assign q_bit   = !diff[NUM_W+1];
    assign n_rem   = q_bit ? diff[NUM_W-1:0] : shifted[NUM_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else begin
            r_ctl <= i_ctl;
        end
        r_rem <= n_rem;
        r_den <= i_den;
        r_quo <= {i_quo[FB-2:0], q_bit};
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ctl.valid && !r_ctl.below && !r_ctl.above |-> r_rem < r_den)
        else $error("divider remainder not below divisor");

endmodule

>>> rtl/scrgb_blend.sv
module scrgb_blend
    import scrgb_pkg::*;
#(
    parameter int FB = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_ctl             i_ctl,
    input  logic [FB-1:0]    i_frac,
    output logic             o_valid,
    output logic [7:0]       o_red,
    output logic [7:0]       o_green,
    output logic [7:0]       o_blue,
    output logic [SEG_W-1:0] o_segment,
    output logic             o_out_of_range
);

    localparam int ACC_W = FB + 10;
    localparam logic signed [ACC_W-1:0] HALF = ACC_W'(1) <<< (FB - 1);

    t_ctl             r_ctl;
    t_rgb             r_mix;
    logic             r_valid;
    t_rgb             r_color;
    logic [SEG_W-1:0] r_segment;
    logic             r_oor;

    t_rgb             c0;
    t_rgb             c1;
    t_rgb             n_mix;
    t_rgb             n_color;
    logic [SEG_W-1:0] n_segment;

    function automatic logic [7:0] mix(input logic [7:0] a, input logic [7:0] b,
                                       input logic [FB-1:0] f);
        logic signed [8:0]       delta;
        logic signed [FB:0]      fs;
        logic signed [ACC_W-1:0] prod;
        logic signed [ACC_W-1:0] acc;
        delta = $signed({1'b0, b}) - $signed({1'b0, a});
        fs    = $signed({1'b0, f});
        prod  = fs * delta;
        acc   = $signed({2'b00, a, {FB{1'b0}}}) + prod + HALF;
        return acc[FB+7:FB];
    endfunction

    assign c0 = ramp_color({1'b0, i_ctl.seg});
    assign c1 = ramp_color({1'b0, i_ctl.seg} + 3'd1);

    assign n_mix.red   = mix(c0.red,   c1.red,   i_frac);
    assign n_mix.green = mix(c0.green, c1.green, i_frac);
    assign n_mix.blue  = mix(c0.blue,  c1.blue,  i_frac);

    // Out-of-range items take the end colours of the ramp.
    always_comb begin
        priority if (r_ctl.below) begin
            n_color   = ramp_color(3'd0);
            n_segment = SEG_FIRST;
        end else if (r_ctl.above) begin
            n_color   = ramp_color(3'd4);
            n_segment = SEG_LAST;
        end else begin
            n_color   = r_mix;
            n_segment = r_ctl.seg;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_ctl   <= i_ctl;
            r_valid <= r_ctl.valid;
        end
        r_mix     <= n_mix;
        r_color   <= n_color;
        r_segment <= n_segment;
        r_oor     <= r_ctl.below || r_ctl.above;
    end

    assign o_valid        = r_valid;
    assign o_red          = r_color.red;
    assign o_green        = r_color.green;
    assign o_blue         = r_color.blue;
    assign o_segment      = r_segment;
    assign o_out_of_range = r_oor;

endmodule
